// ===== hdl/rhht_pkg.sv =====
// rhht_pkg: status codes and fixed field widths for the Robin Hood hash table.
// No dependencies.
`default_nettype none
package rhht_pkg;
  localparam int HashW  = 32;
  localparam int LimitW = 11;
  localparam int StatW  = 3;

  typedef enum logic [StatW-1:0] {
    ST_FOUND    = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_INSERTED = 3'd2,
    ST_UPDATED  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;
endpackage
`default_nettype wire

// ===== hdl/robin_hood_hash_table_top.sv =====
// Robin Hood hash table top level: command port, APB register port, slot memory.
// Depends on rhht_pkg.
//
//  channel   | handshake              | payload
//  command   | start (busy low)       | op, key_hash, value_in
//  result    | done strobe, 1 cycle   | status, value_out
//  register  | APB psel/penable       | load_limit at address 0
//
// Each slot probed takes a read state (S_FRD or S_PRD) then a write/decide state
// (S_FCHK or S_PCHK), as the slot memory is single-port.
// An insert of a new key first runs the search walk, then the displacement walk.
// Reset (rst, synchronous) starts a clearing pass that zeroes every slot entry,
// valid bit included; busy stays high meanwhile. The receiver cannot stall results.
`default_nettype none
module robin_hood_hash_table_top
  import rhht_pkg::*;
#(
  parameter int SLOTS       = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                op,
  input  wire logic [HashW-1:0]    key_hash,
  input  wire logic [31:0]         value_in,
  output logic                     done,
  output logic [StatW-1:0]         status,
  output logic [31:0]              value_out,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [1:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  localparam int AW = $clog2(SLOTS);
  localparam int DW = AW;          // distance fits below SLOTS
  localparam int CW = AW + 1;
  localparam int EW = 1 + HashW + DW + VALUE_WIDTH;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FRD   = 7'b0000100,
    S_FCHK  = 7'b0001000,
    S_PRD   = 7'b0010000,
    S_PCHK  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state;
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd;
  logic          mwe;
  logic [AW-1:0] maddr;
  logic [EW-1:0] mwd;

  logic [LimitW-1:0] load_limit;
  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     steps;
  logic [AW-1:0]     slot;
  logic              cur_op;
  logic [HashW-1:0]  h;
  logic [DW-1:0]     probe_dist;
  logic [VALUE_WIDTH-1:0] v;

  // memory entry fields
  logic                   rv;
  logic [HashW-1:0]       rh;
  logic [DW-1:0]          rdist;
  logic [VALUE_WIDTH-1:0] rval;
  assign {rv, rh, rdist, rval} = rd;

  logic [HashW-1:0] mixed;
  assign mixed = key_hash ^ (key_hash >> 16);

  logic [AW-1:0] slot_inc;
  assign slot_inc = (slot == AW'(SLOTS - 1)) ? '0 : slot + 1'b1;

  logic full;
  assign full = (32'(load_limit) <= 32'(entry_count))
             || (entry_count == CW'(SLOTS));

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwd;
    rd <= mem[maddr];
  end

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? 32'(load_limit) : 32'd0;
  assign busy   = (state != S_IDLE);

  // memory port control
  always_comb begin
    mwe   = 1'b0;
    maddr = slot;
    mwd   = rd;
    case (state)
      S_CLEAR: begin
        mwe = 1'b1;
        mwd = '0;
      end
      S_FCHK: begin
        if (rv && rh == h && cur_op == OP_INSERT) begin
          mwe = 1'b1;
          mwd = {1'b1, rh, rdist, v};
        end
      end
      S_PCHK: begin
        if (!rv || rdist < probe_dist) begin
          mwe = 1'b1;
          mwd = {1'b1, h, probe_dist, v};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      slot        <= '0;
      load_limit  <= LimitW'(819);
      entry_count <= '0;
      done        <= 1'b0;
      steps       <= '0;
    end else begin
      done <= 1'b0;
      if (psel && penable && pwrite && paddr == 2'd0)
        load_limit <= pwdata[LimitW-1:0];
      case (state)
        S_CLEAR: begin
          slot <= slot_inc;
          if (slot == AW'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur_op     <= op;
            h          <= mixed;
            v          <= VALUE_WIDTH'(value_in);
            slot       <= mixed[AW-1:0];
            probe_dist <= '0;
            steps      <= '0;
            state      <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (rv && rh == h) begin
            done      <= 1'b1;
            status    <= (cur_op == OP_LOOKUP) ? ST_FOUND : ST_UPDATED;
            value_out <= (cur_op == OP_LOOKUP) ? 32'(rval) : 32'd0;
            state     <= S_WAIT;
          end else if (!rv || rdist < probe_dist || steps == CW'(SLOTS - 1)) begin
            value_out <= '0;
            if (cur_op == OP_LOOKUP) begin
              done <= 1'b1; status <= ST_NOTFOUND; state <= S_WAIT;
            end else if (full) begin
              done <= 1'b1; status <= ST_FULL; state <= S_WAIT;
            end else begin
              slot       <= h[AW-1:0];
              probe_dist <= '0;
              state      <= S_PRD;
            end
          end else begin
            slot       <= slot_inc;
            probe_dist <= probe_dist + 1'b1;
            steps      <= steps + 1'b1;
            state      <= S_FRD;
          end
        end
        S_PRD: state <= S_PCHK;
        S_PCHK: begin
          if (!rv) begin
            entry_count <= entry_count + 1'b1;
            done   <= 1'b1;
            status <= ST_INSERTED;
            state  <= S_WAIT;
          end else begin
            if (rdist < probe_dist) begin
              h          <= rh;
              v          <= rval;
              probe_dist <= rdist + 1'b1;
            end else begin
              probe_dist <= probe_dist + 1'b1;
            end
            slot  <= slot_inc;
            state <= S_PRD;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
